### hdl/twp_pkg.sv
// twp_pkg: shared types, constants and helper functions of the twist deformer
`timescale 1ns / 1ps
package twp_pkg;

  localparam int COORD_W       = 32;
  localparam int AXIS_W        = 16;
  localparam int RATE_W        = 32;
  localparam int SINCOS_STAGES = 16;
  localparam int ATAN_N        = 24;
  localparam int NSTEP         = (SINCOS_STAGES < ATAN_N) ? SINCOS_STAGES : ATAN_N;
  // angle unit: one register for phase split, the steps, one for quadrant fix-up
  localparam int CORDIC_LAT    = NSTEP + 2;
  localparam int CS_W          = 34;
  localparam int C14_W         = CS_W - 16;
  localparam int PROD_W        = COORD_W + AXIS_W;
  localparam int DOT_W         = COORD_W + AXIS_W + 2;
  localparam int RK_W          = 62;
  localparam int PH_W          = 86;
  localparam int PHASE_LSB     = 54;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  localparam logic signed [RATE_W-1:0] RATE_EPS   = 32'sd17;
  localparam logic signed [30:0]       TURNS_K    = 31'sd683565276;
  localparam logic signed [CS_W-1:0]   CORDIC_X0  = 34'sd652032874;
  localparam logic signed [C14_W:0]    ONE_Q14    = 19'sd16384;

  // register indexes
  localparam logic [2:0] REG_RATE = 3'd0;
  localparam logic [2:0] REG_OX   = 3'd1;
  localparam logic [2:0] REG_OY   = 3'd2;
  localparam logic [2:0] REG_OZ   = 3'd3;
  localparam logic [2:0] REG_AX   = 3'd4;
  localparam logic [2:0] REG_AY   = 3'd5;
  localparam logic [2:0] REG_AZ   = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    coord_t ox;
    coord_t oy;
    coord_t oz;
    axis_t  ax;
    axis_t  ay;
    axis_t  az;
  } cfg_t;

  typedef struct packed {
    logic   byp;
    coord_t vx;
    coord_t vy;
    coord_t vz;
  } item_t;

  // round half up from Q.14 and wrap to coordinate width
  function automatic coord_t rnd14(input logic signed [63:0] x);
    logic [63:0] s;
    s = x + 64'sd8192;
    return s[COORD_W+13:14];
  endfunction

  // arctangent of 2^-i in Q0.32 turns
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

### hdl/twp_point_if.sv
// twp_point_if: input point channel
`timescale 1ns / 1ps
interface twp_point_if;
  import twp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

### hdl/twp_moved_if.sv
// twp_moved_if: output point channel
`timescale 1ns / 1ps
interface twp_moved_if;
  import twp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t moved_x;
  coord_t moved_y;
  coord_t moved_z;
  modport source (output valid, output moved_x, output moved_y, output moved_z, input ready);
  modport sink (input valid, input moved_x, input moved_y, input moved_z, output ready);
endinterface

### hdl/twp_front.sv
// twp_front: accepts points, forms offset from origin and flags the pass-through case
`timescale 1ns / 1ps
module twp_front (
  input  logic          clk,
  input  logic          rst,
  twp_point_if.sink     points,
  input  twp_pkg::cfg_t cfg,
  output twp_pkg::item_t item,
  output logic          item_valid,
  input  logic          item_ready
);
  import twp_pkg::*;

  logic take;

  assign points.ready = !item_valid || item_ready;
  assign take = points.valid && points.ready;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  // offset and small-rate classification
  always_ff @(posedge clk) begin
    if (take) begin
      item.byp <= ($signed(cfg.rate) < RATE_EPS) && ($signed(cfg.rate) > -RATE_EPS);
      item.vx  <= points.point_x - cfg.ox;
      item.vy  <= points.point_y - cfg.oy;
      item.vz  <= points.point_z - cfg.oz;
    end
  end
endmodule

### hdl/twp_fifo.sv
// twp_fifo: short queue between the front and the back
`timescale 1ns / 1ps
module twp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  twp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output twp_pkg::item_t head,
  output logic           empty
);
  import twp_pkg::*;

  item_t              mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

### hdl/twp_cordic.sv
// twp_cordic: pipelined sine and cosine of a phase in turns
`timescale 1ns / 1ps
module twp_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic [31:0]                       phase,
  output logic signed [twp_pkg::C14_W-1:0]  c14,
  output logic signed [twp_pkg::C14_W-1:0]  s14
);
  import twp_pkg::*;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic signed [CS_W-1:0] xs [0:NSTEP];
  logic signed [CS_W-1:0] ys [0:NSTEP];
  logic signed [CS_W-1:0] zs [0:NSTEP];
  logic [1:0]             qs [0:NSTEP];
  logic [31:0]            pq;
  logic [31:0]            res;
  logic signed [CS_W-1:0] cf;
  logic signed [CS_W-1:0] sf;

  // quadrant split, residual within an eighth of a turn
  always_comb begin
    pq  = phase + 32'h2000_0000;
    res = phase - {pq[31:30], 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_X0;
      ys[0] <= '0;
      zs[0] <= CS_W'($signed(res));
      qs[0] <= pq[31:30];
    end
  end

  // rotation steps
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam logic signed [CS_W-1:0] ATAN = CS_W'(atan_turn(i));
    logic signed [CS_W-1:0] sx;
    logic signed [CS_W-1:0] sy;
    assign sx = xs[i] >>> i;
    assign sy = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        qs[i+1] <= qs[i];
        if (!zs[i][CS_W-1]) begin
          xs[i+1] <= xs[i] - sy;
          ys[i+1] <= ys[i] + sx;
          zs[i+1] <= zs[i] - ATAN;
        end else begin
          xs[i+1] <= xs[i] + sy;
          ys[i+1] <= ys[i] - sx;
          zs[i+1] <= zs[i] + ATAN;
        end
      end
    end
  end

  // quadrant fix-up
  always_comb begin
    case (qs[NSTEP])
      QUAD_0: begin cf = xs[NSTEP];  sf = ys[NSTEP];  end
      QUAD_1: begin cf = -ys[NSTEP]; sf = xs[NSTEP];  end
      QUAD_2: begin cf = -xs[NSTEP]; sf = -ys[NSTEP]; end
      QUAD_3: begin cf = ys[NSTEP];  sf = -xs[NSTEP]; end
      default: begin cf = xs[NSTEP]; sf = ys[NSTEP]; end
    endcase
  end

  // round to Q4.14
  always_ff @(posedge clk) begin
    if (en) begin
      c14 <= C14_W'((cf + CS_W'(32768)) >>> 16);
      s14 <= C14_W'((sf + CS_W'(32768)) >>> 16);
    end
  end

  logic unused_z;
  assign unused_z = ^zs[NSTEP];
endmodule

### hdl/twp_back.sv
// twp_back: arithmetic pipeline that twists one point per cycle while the output is not held
`timescale 1ns / 1ps
module twp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  twp_pkg::cfg_t                 cfg,
  input  logic signed [twp_pkg::RK_W-1:0] rk,
  input  twp_pkg::item_t                head,
  input  logic                          empty,
  output logic                          pop,
  twp_moved_if.source                   moved
);
  import twp_pkg::*;

  localparam int NV = 5 + CORDIC_LAT + 1;

  typedef struct packed {
    logic   byp;
    coord_t vx, vy, vz;
    coord_t crx, cry, crz;
    coord_t ktx, kty, ktz;
  } pay_t;

  logic adv;
  logic [NV-1:0] vld;

  assign adv = !moved.valid || moved.ready;
  assign pop = adv && !empty;

  // valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      moved.valid <= 1'b0;
    end else if (adv) begin
      vld         <= {vld[NV-2:0], !empty};
      moved.valid <= vld[NV-1];
    end
  end

  // stage 1: products for dot and cross
  logic signed [PROD_W-1:0] d1x, d1y, d1z;
  logic signed [PROD_W-1:0] kyvz, kzvy, kzvx, kxvz, kxvy, kyvx;
  item_t it1;
  always_ff @(posedge clk) begin
    if (adv) begin
      it1  <= head;
      d1x  <= $signed(cfg.ax) * $signed(head.vx);
      d1y  <= $signed(cfg.ay) * $signed(head.vy);
      d1z  <= $signed(cfg.az) * $signed(head.vz);
      kyvz <= $signed(cfg.ay) * $signed(head.vz);
      kzvy <= $signed(cfg.az) * $signed(head.vy);
      kzvx <= $signed(cfg.az) * $signed(head.vx);
      kxvz <= $signed(cfg.ax) * $signed(head.vz);
      kxvy <= $signed(cfg.ax) * $signed(head.vy);
      kyvx <= $signed(cfg.ay) * $signed(head.vx);
    end
  end

  // stage 2: dot sum and rounded cross product
  logic signed [DOT_W-1:0] dot2;
  pay_t p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      dot2   <= DOT_W'(d1x) + DOT_W'(d1y) + DOT_W'(d1z);
      p2.byp <= it1.byp;
      p2.vx  <= it1.vx;
      p2.vy  <= it1.vy;
      p2.vz  <= it1.vz;
      p2.crx <= rnd14(64'(kyvz) - 64'(kzvy));
      p2.cry <= rnd14(64'(kzvx) - 64'(kxvz));
      p2.crz <= rnd14(64'(kxvy) - 64'(kyvx));
      p2.ktx <= '0;
      p2.kty <= '0;
      p2.ktz <= '0;
    end
  end

  // stage 3: partial products of dot by rate in turns, axial length
  logic signed [32:0]         dlo, rlo;
  logic signed [DOT_W-33:0]   dhi;
  logic signed [RK_W-33:0]    rhi;
  logic signed [65:0]         pll;
  logic signed [63:0]         plh;
  logic signed [DOT_W+32-32:0] phl;
  logic signed [DOT_W-32+RK_W-32-1:0] phh;
  coord_t t3;
  pay_t   p3;
  assign dlo = $signed({1'b0, dot2[31:0]});
  assign dhi = dot2[DOT_W-1:32];
  assign rlo = $signed({1'b0, rk[31:0]});
  assign rhi = rk[RK_W-1:32];
  always_ff @(posedge clk) begin
    if (adv) begin
      pll <= dlo * rlo;
      plh <= 64'(dlo * rhi);
      phl <= dhi * rlo;
      phh <= dhi * rhi;
      t3  <= rnd14(64'(dot2));
      p3  <= p2;
    end
  end

  // stage 4: middle sum, axial components
  logic signed [65:0] ll4;
  logic signed [63:0] mid4;
  logic signed [DOT_W-32+RK_W-32-1:0] hh4;
  pay_t p4;
  always_ff @(posedge clk) begin
    if (adv) begin
      ll4    <= pll;
      hh4    <= phh;
      mid4   <= plh + 64'(phl);
      p4.byp <= p3.byp;
      p4.vx  <= p3.vx;
      p4.vy  <= p3.vy;
      p4.vz  <= p3.vz;
      p4.crx <= p3.crx;
      p4.cry <= p3.cry;
      p4.crz <= p3.crz;
      p4.ktx <= rnd14(64'($signed(cfg.ax) * t3));
      p4.kty <= rnd14(64'($signed(cfg.ay) * t3));
      p4.ktz <= rnd14(64'($signed(cfg.az) * t3));
    end
  end

  // stage 5: phase in turns
  logic [PH_W-1:0] tot;
  logic [31:0]     phase5;
  pay_t            p5;
  assign tot = PH_W'(ll4) + (PH_W'(mid4) << 32) + (PH_W'(hh4) << 64);
  always_ff @(posedge clk) begin
    if (adv) begin
      phase5 <= tot[PHASE_LSB+31:PHASE_LSB];
      p5     <= p4;
    end
  end

  // sine and cosine, payload delayed alongside
  logic signed [C14_W-1:0] c14, s14;
  pay_t dl [0:CORDIC_LAT-1];

  twp_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .phase (phase5),
    .c14   (c14),
    .s14   (s14)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= p5;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  // stage m: rotation products
  logic signed [C14_W:0] omc;
  logic signed [COORD_W+C14_W-1:0] mvx, mvy, mvz, msx, msy, msz;
  logic signed [COORD_W+C14_W:0]   mkx, mky, mkz;
  logic   bm;
  coord_t vmx, vmy, vmz;
  assign omc = ONE_Q14 - (C14_W+1)'(c14);
  always_ff @(posedge clk) begin
    if (adv) begin
      bm  <= dl[CORDIC_LAT-1].byp;
      vmx <= dl[CORDIC_LAT-1].vx;
      vmy <= dl[CORDIC_LAT-1].vy;
      vmz <= dl[CORDIC_LAT-1].vz;
      mvx <= $signed(dl[CORDIC_LAT-1].vx) * c14;
      mvy <= $signed(dl[CORDIC_LAT-1].vy) * c14;
      mvz <= $signed(dl[CORDIC_LAT-1].vz) * c14;
      msx <= $signed(dl[CORDIC_LAT-1].crx) * s14;
      msy <= $signed(dl[CORDIC_LAT-1].cry) * s14;
      msz <= $signed(dl[CORDIC_LAT-1].crz) * s14;
      mkx <= $signed(dl[CORDIC_LAT-1].ktx) * omc;
      mky <= $signed(dl[CORDIC_LAT-1].kty) * omc;
      mkz <= $signed(dl[CORDIC_LAT-1].ktz) * omc;
    end
  end

  // final sum and rounding; bypassed points keep their offset
  coord_t rx, ry, rz;
  assign rx = bm ? vmx : rnd14(64'(mvx) + 64'(msx) + 64'(mkx));
  assign ry = bm ? vmy : rnd14(64'(mvy) + 64'(msy) + 64'(mky));
  assign rz = bm ? vmz : rnd14(64'(mvz) + 64'(msz) + 64'(mkz));

  // output register, origin added back
  always_ff @(posedge clk) begin
    if (adv) begin
      moved.moved_x <= rx + cfg.ox;
      moved.moved_y <= ry + cfg.oy;
      moved.moved_z <= rz + cfg.oz;
    end
  end
endmodule

### hdl/twist_deform_point_core.sv
// twist_deform_point_core: twist deformer top level with register file
//
// Twists each Q16.16 point about the axis through origin_x/y/z along axis_x/y/z by
// twist_rate radians per unit of axial distance; with |twist_rate| below 17 LSB the
// point passes unchanged. One point is accepted per clock and results leave one per
// clock in order while the output is not held; a point passes through the front
// register, the queue, five dot and phase stages, the pipelined CORDIC unit of
// SINCOS_STAGES + 2 stages, the product stage and the output register.
// A four-entry queue separates intake from the arithmetic pipeline, which stalls
// as a whole only while the output is held.
// Registers are written through cfg_we/cfg_index/cfg_data while no point is in
// flight; the axis is used as written, so software supplies a unit vector.
`timescale 1ns / 1ps
module twist_deform_point_core (
  input  logic        clk,
  input  logic        rst,
  twp_point_if.sink   points,
  twp_moved_if.source moved,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import twp_pkg::*;

  cfg_t                   cfg;
  logic signed [RK_W-1:0] rk;
  item_t                  fitem;
  logic                   fvalid;
  logic                   ffull;
  item_t                  head;
  logic                   empty;
  logic                   pop;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate <= '0;
      cfg.ox   <= '0;
      cfg.oy   <= '0;
      cfg.oz   <= '0;
      cfg.ax   <= '0;
      cfg.ay   <= 16'sd16384;
      cfg.az   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE: cfg.rate <= cfg_data;
        REG_OX:   cfg.ox   <= cfg_data[COORD_W-1:0];
        REG_OY:   cfg.oy   <= cfg_data[COORD_W-1:0];
        REG_OZ:   cfg.oz   <= cfg_data[COORD_W-1:0];
        REG_AX:   cfg.ax   <= cfg_data[AXIS_W-1:0];
        REG_AY:   cfg.ay   <= cfg_data[AXIS_W-1:0];
        REG_AZ:   cfg.az   <= cfg_data[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // rate in turns per unit, Q0.32 scaling folded in
  always_ff @(posedge clk) begin
    if (rst) begin
      rk <= '0;
    end else begin
      rk <= RK_W'($signed(cfg.rate) * TURNS_K);
    end
  end

  twp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .points     (points),
    .cfg        (cfg),
    .item       (fitem),
    .item_valid (fvalid),
    .item_ready (!ffull)
  );

  twp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fvalid),
    .push_item (fitem),
    .full      (ffull),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  twp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .rk    (rk),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .moved (moved)
  );
endmodule
